// ----- hw/rtl/cdt_pkg.sv -----
// shared types, codes and constants of the countdown timer display unit
`default_nettype none

package cdt_pkg;

   // default parameter values
   localparam int DEF_GLYPH_WIDTH      = 10;
   localparam int DEF_GLYPH_HEIGHT     = 11;
   localparam int DEF_MAX_LOAD_SECONDS = 9999;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int LOAD_W     = 14;
   localparam int ROW_W      = 4;
   localparam int POS_W      = 3;
   localparam int MIN_W      = 8;
   localparam int SEC_W      = 6;
   localparam int COUNT_W    = 3;
   localparam int DIGIT_W    = 4;
   localparam int MASK_W     = 10;
   localparam int RWIDTH_W   = 4;
   localparam int MAX_GLYPH_W = 16;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

   // glyph row shapes
   localparam logic [2:0] ROW_BLANK = 3'd0;
   localparam logic [2:0] ROW_FULL  = 3'd1;
   localparam logic [2:0] ROW_BOX   = 3'd2;
   localparam logic [2:0] ROW_LEFT  = 3'd3;
   localparam logic [2:0] ROW_RIGHT = 3'd4;
   localparam logic [2:0] ROW_ONE   = 3'd5;

   // digit counts
   localparam logic [COUNT_W-1:0] COUNT_SHORT = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_LONG  = 3'd5;
   localparam logic [MIN_W-1:0]   LONG_MINUTES = 8'd100;

   // reciprocal of 60 scaled by 2^20, exact for values below 23831
   localparam int RECIP60_SHIFT = 20;
   localparam logic [14:0] RECIP60 = 15'd17477;
   // reciprocals of 10 (2^11) and 100 (2^12), exact for 8-bit values
   localparam int RECIP10_SHIFT  = 11;
   localparam logic [7:0] RECIP10  = 8'd205;
   localparam int RECIP100_SHIFT = 12;
   localparam logic [7:0] RECIP100 = 8'd41;

   localparam logic [SEC_W-1:0] LAST_SECOND = 6'd59;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [LOAD_W-1:0]   load_seconds;
      logic [ROW_W-1:0]    row_index;
      logic [POS_W-1:0]    digit_position;
   } request_type;

   typedef struct packed {
      logic [MIN_W-1:0]   minutes_left;
      logic [SEC_W-1:0]   seconds_left;
      logic               running;
      logic               beep;
      logic               load_rejected;
      logic [COUNT_W-1:0] digit_count;
   } timer_status_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]  digit_value;
      logic [MASK_W-1:0]   row_mask;
      logic [RWIDTH_W-1:0] row_width;
   } glyph_result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/cdt_count_core.sv -----
// countdown state registers with load split and tick borrow logic
`default_nettype none

module cdt_count_core
   import cdt_pkg::*;
#(
   parameter int MAX_LOAD_SECONDS = DEF_MAX_LOAD_SECONDS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire request_type      item,
   output timer_status_type     status,
   output logic [MIN_W-1:0]     cur_minutes,
   output logic [SEC_W-1:0]     cur_seconds
);

   logic [MIN_W-1:0] minutes_ff, minutes_in;
   logic [SEC_W-1:0] seconds_ff, seconds_in;
   logic             counting_ff, counting_in;

   logic [28:0]      quot_prod;
   logic [MIN_W-1:0] load_minutes;
   logic [LOAD_W-1:0] minutes_x60;
   logic [SEC_W-1:0] load_secs;
   logic             too_big;
   logic             beep;

   // split by 60 through a reciprocal multiply, remainder by shift-subtract
   assign quot_prod    = 29'(item.load_seconds) * 29'(RECIP60);
   assign load_minutes = MIN_W'(quot_prod >> RECIP60_SHIFT);
   assign minutes_x60  = LOAD_W'({load_minutes, 6'b0}) - LOAD_W'({load_minutes, 2'b0});
   assign load_secs    = SEC_W'(item.load_seconds - minutes_x60);
   assign too_big      = item.load_seconds > LOAD_W'(MAX_LOAD_SECONDS);

   always_comb begin
      minutes_in  = minutes_ff;
      seconds_in  = seconds_ff;
      counting_in = counting_ff;
      beep        = 1'b0;
      case (item.action)
         ACT_LOAD: begin
            if (!too_big) begin
               minutes_in  = load_minutes;
               seconds_in  = load_secs;
               counting_in = 1'b1;
            end
         end
         ACT_TICK: begin
            if (counting_ff) begin
               if (minutes_ff == '0 && seconds_ff == '0) begin
                  counting_in = 1'b0;
                  beep        = 1'b1;
               end else if (seconds_ff == '0) begin
                  minutes_in = minutes_ff - MIN_W'(1);
                  seconds_in = LAST_SECOND;
               end else begin
                  seconds_in = seconds_ff - SEC_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minutes_ff  <= '0;
         seconds_ff  <= '0;
         counting_ff <= 1'b0;
      end else if (step_en) begin
         minutes_ff  <= minutes_in;
         seconds_ff  <= seconds_in;
         counting_ff <= counting_in;
      end
   end

   always_comb begin
      status.minutes_left  = minutes_in;
      status.seconds_left  = seconds_in;
      status.running       = counting_in;
      status.beep          = beep;
      status.load_rejected = (item.action == ACT_LOAD) && too_big;
      status.digit_count   = (minutes_in >= LONG_MINUTES) ? COUNT_LONG : COUNT_SHORT;
   end

   assign cur_minutes = minutes_ff;
   assign cur_seconds = seconds_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cdt_glyph_row.sv -----
// display digit selection and glyph row lookup for a query
`default_nettype none

module cdt_glyph_row
   import cdt_pkg::*;
#(
   parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
   parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
   input  wire request_type        item,
   input  wire logic [MIN_W-1:0]   minutes,
   input  wire logic [SEC_W-1:0]   seconds,
   input  wire logic [COUNT_W-1:0] digit_count,
   output glyph_result_type        result
);

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_HEIGHT - 1);
   localparam logic [ROW_W-1:0] ROW_MID  = ROW_W'((GLYPH_HEIGHT - 1) / 2);
   localparam logic [MAX_GLYPH_W-1:0] FULL_WIDE  =
      MAX_GLYPH_W'((32'd1 << GLYPH_WIDTH) - 32'd1);
   localparam logic [MAX_GLYPH_W-1:0] RIGHT_WIDE =
      MAX_GLYPH_W'(32'd1 << (GLYPH_WIDTH - 1));
   localparam logic [MASK_W-1:0] MASK_FULL  = FULL_WIDE[MASK_W-1:0];
   localparam logic [MASK_W-1:0] MASK_RIGHT = RIGHT_WIDE[MASK_W-1:0];
   localparam logic [MASK_W-1:0] MASK_LEFT  = MASK_W'(1);

   logic [15:0]        hund_prod, tens_prod, sec_prod;
   logic [DIGIT_W-1:0] m_hund, m_ones, s_tens, s_ones;
   logic [4:0]         m_tens_all;
   logic [DIGIT_W-1:0] m_tens;
   logic [DIGIT_W-1:0] dval;
   logic [2:0]         shape;
   logic               pos_ok;

   // minute and second digits by reciprocal multiplies on narrow values
   assign hund_prod  = 16'(minutes) * 16'(RECIP100);
   assign tens_prod  = 16'(minutes) * 16'(RECIP10);
   assign sec_prod   = 16'(seconds) * 16'(RECIP10);
   assign m_hund     = DIGIT_W'(hund_prod >> RECIP100_SHIFT);
   assign m_tens_all = 5'(tens_prod >> RECIP10_SHIFT);
   assign m_ones     = DIGIT_W'(minutes - MIN_W'({m_tens_all, 3'b0}) - MIN_W'({m_tens_all, 1'b0}));
   assign s_tens     = DIGIT_W'(sec_prod >> RECIP10_SHIFT);
   assign s_ones     = DIGIT_W'(seconds - SEC_W'({s_tens, 3'b0}) - SEC_W'({s_tens, 1'b0}));

   always_comb begin
      if (m_tens_all >= 5'd20) begin
         m_tens = DIGIT_W'(m_tens_all - 5'd20);
      end else if (m_tens_all >= 5'd10) begin
         m_tens = DIGIT_W'(m_tens_all - 5'd10);
      end else begin
         m_tens = DIGIT_W'(m_tens_all);
      end
   end

   assign pos_ok = COUNT_W'(item.digit_position) < digit_count;

   // digit at the asked position, MMSS or MMMSS layout
   always_comb begin
      dval = '0;
      if (digit_count == COUNT_LONG) begin
         case (item.digit_position)
            3'd0:    dval = m_hund;
            3'd1:    dval = m_tens;
            3'd2:    dval = m_ones;
            3'd3:    dval = s_tens;
            3'd4:    dval = s_ones;
            default: dval = '0;
         endcase
      end else begin
         case (item.digit_position)
            3'd0:    dval = m_tens;
            3'd1:    dval = m_ones;
            3'd2:    dval = s_tens;
            3'd3:    dval = s_ones;
            default: dval = '0;
         endcase
      end
   end

   // row shape of the seven-segment style glyph
   always_comb begin
      if ({1'b0, item.row_index} >= 5'(GLYPH_HEIGHT)) begin
         shape = ROW_BLANK;
      end else if (dval == 4'd1) begin
         shape = ROW_ONE;
      end else if (item.row_index == '0) begin
         shape = (dval == 4'd4) ? ROW_BOX : ROW_FULL;
      end else if (item.row_index == ROW_LAST) begin
         shape = (dval inside {4'd4, 4'd7}) ? ROW_RIGHT : ROW_FULL;
      end else if (item.row_index == ROW_MID) begin
         if (dval == 4'd0) begin
            shape = ROW_BOX;
         end else if (dval == 4'd7) begin
            shape = ROW_RIGHT;
         end else begin
            shape = ROW_FULL;
         end
      end else if (item.row_index < ROW_MID) begin
         if (dval inside {4'd0, 4'd4, 4'd8, 4'd9}) begin
            shape = ROW_BOX;
         end else if (dval inside {4'd5, 4'd6}) begin
            shape = ROW_LEFT;
         end else begin
            shape = ROW_RIGHT;
         end
      end else begin
         if (dval inside {4'd0, 4'd6, 4'd8}) begin
            shape = ROW_BOX;
         end else if (dval == 4'd2) begin
            shape = ROW_LEFT;
         end else begin
            shape = ROW_RIGHT;
         end
      end
   end

   always_comb begin
      result = '0;
      if (item.action == ACT_QUERY && pos_ok) begin
         result.digit_value = dval;
         case (shape)
            ROW_FULL: begin
               result.row_mask  = MASK_FULL;
               result.row_width = RWIDTH_W'(GLYPH_WIDTH);
            end
            ROW_BOX: begin
               result.row_mask  = MASK_LEFT | MASK_RIGHT;
               result.row_width = RWIDTH_W'(GLYPH_WIDTH);
            end
            ROW_LEFT: begin
               result.row_mask  = MASK_LEFT;
               result.row_width = RWIDTH_W'(GLYPH_WIDTH);
            end
            ROW_RIGHT: begin
               result.row_mask  = MASK_RIGHT;
               result.row_width = RWIDTH_W'(GLYPH_WIDTH);
            end
            ROW_ONE: begin
               result.row_mask  = MASK_LEFT;
               result.row_width = RWIDTH_W'(1);
            end
            default: begin
               result.row_mask  = '0;
               result.row_width = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/countdown_timer_mm_ss_display_unit.sv -----
// top level of the countdown timer with minutes:seconds glyph display
// a request is held in the request register, and its response in the response register
// throughput: one request per cycle while the receiver does not stall, set by the single-pass compute stage
// between the request register and the response register
// reset: synchronous active-high; clears both valid flags and the timer state
`default_nettype none

module countdown_timer_mm_ss_display_unit
   import cdt_pkg::*;
#(
   parameter int GLYPH_WIDTH      = DEF_GLYPH_WIDTH,
   parameter int GLYPH_HEIGHT     = DEF_GLYPH_HEIGHT,
   parameter int MAX_LOAD_SECONDS = DEF_MAX_LOAD_SECONDS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [LOAD_W-1:0]   req_load_seconds,
   input  wire logic [ROW_W-1:0]    req_row_index,
   input  wire logic [POS_W-1:0]    req_digit_position,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [MIN_W-1:0]         rsp_minutes_left,
   output logic [SEC_W-1:0]         rsp_seconds_left,
   output logic                     rsp_running,
   output logic                     rsp_beep,
   output logic                     rsp_load_rejected,
   output logic [COUNT_W-1:0]       rsp_digit_count,
   output logic [DIGIT_W-1:0]       rsp_digit_value,
   output logic [MASK_W-1:0]        rsp_row_mask,
   output logic [RWIDTH_W-1:0]      rsp_row_width
);

   // request register
   logic             in_valid_ff, in_valid_in;
   request_type      in_item_ff;

   // response register
   logic             out_valid_ff, out_valid_in;
   timer_status_type out_status_ff;
   glyph_result_type out_glyph_ff;

   logic             req_accept;
   logic             advance;
   timer_status_type status;
   glyph_result_type glyph;
   logic [MIN_W-1:0] cur_minutes;
   logic [SEC_W-1:0] cur_seconds;

   // the held request moves on when the response slot is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // stall only while a request is held and cannot move on
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.action         <= req_action;
         in_item_ff.load_seconds   <= req_load_seconds;
         in_item_ff.row_index      <= req_row_index;
         in_item_ff.digit_position <= req_digit_position;
      end
      if (advance) begin
         out_status_ff <= status;
         out_glyph_ff  <= glyph;
      end
   end

   // timer state, updated once per request as it moves to the response stage
   cdt_count_core #(
      .MAX_LOAD_SECONDS (MAX_LOAD_SECONDS)
   ) u_count (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (in_item_ff),
      .status      (status),
      .cur_minutes (cur_minutes),
      .cur_seconds (cur_seconds)
   );

   // a query leaves the state alone, so the registered state is the display value
   cdt_glyph_row #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_glyph (
      .item        (in_item_ff),
      .minutes     (cur_minutes),
      .seconds     (cur_seconds),
      .digit_count (status.digit_count),
      .result      (glyph)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_minutes_left  = out_status_ff.minutes_left;
   assign rsp_seconds_left  = out_status_ff.seconds_left;
   assign rsp_running       = out_status_ff.running;
   assign rsp_beep          = out_status_ff.beep;
   assign rsp_load_rejected = out_status_ff.load_rejected;
   assign rsp_digit_count   = out_status_ff.digit_count;
   assign rsp_digit_value   = out_glyph_ff.digit_value;
   assign rsp_row_mask      = out_glyph_ff.row_mask;
   assign rsp_row_width     = out_glyph_ff.row_width;

`ifndef SYNTHESIS
   // a beep always stops the countdown
   a_beep_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beep |-> !rsp_running)
      else $error("beep while still running");

   // seconds never leave the 0..59 range
   a_seconds_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seconds_left <= LAST_SECOND)
      else $error("seconds out of range");

   // digit count follows the minute count
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_minutes_left >= LONG_MINUTES) == (rsp_digit_count == COUNT_LONG)))
      else $error("digit count does not match minutes");

   // beep and reject come from different actions
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_beep && rsp_load_rejected))
      else $error("beep and reject together");

   // a response advanced into the output register is presented next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced request not presented");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the countdown timer display unit, directed and random requests
module tb;
   import cdt_pkg::*;

   // action 3 has no name in the package; the block must leave everything alone
   localparam logic [ACTION_W-1:0] ACT_IDLE = 2'd3;

   localparam int RANDOM_REQUESTS      = 1050;
   localparam int WATCHDOG_LIMIT       = 2000;
   localparam int LONG_HOLD_CYCLES     = 300;
   localparam int HOLD_AFTER_RESPONSES = 400;
   // drain margin at the end of the run
   localparam int DRAIN_CYCLES         = 8;

   // glyph geometry at the default parameters
   localparam int GLYPH_MID  = (DEF_GLYPH_HEIGHT - 1) / 2;
   localparam int GLYPH_LAST = DEF_GLYPH_HEIGHT - 1;
   localparam logic [MASK_W-1:0] MASK_FULL  = MASK_W'((1 << DEF_GLYPH_WIDTH) - 1);
   localparam logic [MASK_W-1:0] MASK_LEFT  = MASK_W'(1);
   localparam logic [MASK_W-1:0] MASK_RIGHT = MASK_W'(1 << (DEF_GLYPH_WIDTH - 1));

   typedef struct packed {
      timer_status_type status;
      glyph_result_type glyph;
   } timer_response_type;

   // clock, reset and the ports the bench drives, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action         = ACT_IDLE;
   logic [LOAD_W-1:0]   req_load_seconds   = '0;
   logic [ROW_W-1:0]    req_row_index      = '0;
   logic [POS_W-1:0]    req_digit_position = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [MIN_W-1:0]    rsp_minutes_left;
   logic [SEC_W-1:0]    rsp_seconds_left;
   logic                rsp_running;
   logic                rsp_beep;
   logic                rsp_load_rejected;
   logic [COUNT_W-1:0]  rsp_digit_count;
   logic [DIGIT_W-1:0]  rsp_digit_value;
   logic [MASK_W-1:0]   rsp_row_mask;
   logic [RWIDTH_W-1:0] rsp_row_width;

   countdown_timer_mm_ss_display_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_load_seconds   (req_load_seconds),
      .req_row_index      (req_row_index),
      .req_digit_position (req_digit_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_minutes_left   (rsp_minutes_left),
      .rsp_seconds_left   (rsp_seconds_left),
      .rsp_running        (rsp_running),
      .rsp_beep           (rsp_beep),
      .rsp_load_rejected  (rsp_load_rejected),
      .rsp_digit_count    (rsp_digit_count),
      .rsp_digit_value    (rsp_digit_value),
      .rsp_row_mask       (rsp_row_mask),
      .rsp_row_width      (rsp_row_width)
   );

   always #5 clock = ~clock;

   // request stream and the displays it should produce, oldest first
   request_type        pending_requests[$];
   timer_response_type expected_displays[$];

   // timer state as the bench sees it
   logic [MIN_W-1:0] timer_minutes  = '0;
   logic [SEC_W-1:0] timer_seconds  = '0;
   logic             timer_counting = 1'b0;

   // bookkeeping
   logic req_fire = 1'b0;  // request taken at the last rising edge
   int   mismatch_count    = 0;
   int   requests_accepted = 0;
   int   responses_checked = 0;
   int   rejected_loads    = 0;
   int   expired_countdowns = 0;
   int   lit_rows          = 0;
   int   long_display_rows = 0;
   int   idle_cycles       = 0;
   timer_response_type oldest_display;
   timer_response_type next_display;

   // sender burst shaping
   int burst_left = 0;
   int gap_left   = 0;

   // receiver stall pattern
   int  stall_mode   = 0;
   int  phase_left   = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;

   // advance the timer by one request and work out the display it reports
   function automatic timer_response_type timer_display_predict(request_type rq);
      timer_response_type r;
      logic [DIGIT_W-1:0] digits [0:4];
      logic [DIGIT_W-1:0] dv;
      logic [2:0]         shape;
      int unsigned        m, s, row;
      r = '0;
      case (rq.action)
         ACT_LOAD: begin
            if (rq.load_seconds > DEF_MAX_LOAD_SECONDS) begin
               // out of range: flag it and keep the old count
               r.status.load_rejected = 1'b1;
            end else begin
               timer_minutes  = MIN_W'(rq.load_seconds / 60);
               timer_seconds  = SEC_W'(rq.load_seconds % 60);
               timer_counting = 1'b1;
            end
         end
         ACT_TICK: begin
            if (timer_counting) begin
               if (timer_minutes == 0 && timer_seconds == 0) begin
                  // tick that finds zero stops the countdown and beeps
                  timer_counting = 1'b0;
                  r.status.beep  = 1'b1;
               end else if (timer_seconds == 0) begin
                  // borrow a minute
                  timer_minutes = timer_minutes - MIN_W'(1);
                  timer_seconds = LAST_SECOND;
               end else begin
                  timer_seconds = timer_seconds - SEC_W'(1);
               end
            end
         end
         default: ;
      endcase

      r.status.minutes_left = timer_minutes;
      r.status.seconds_left = timer_seconds;
      r.status.running      = timer_counting;
      r.status.digit_count  = (timer_minutes >= LONG_MINUTES) ? COUNT_LONG : COUNT_SHORT;

      if (rq.action == ACT_QUERY && rq.digit_position < r.status.digit_count) begin
         m = 32'(timer_minutes);
         s = 32'(timer_seconds);
         if (r.status.digit_count == COUNT_LONG) begin
            digits[0] = DIGIT_W'((m / 100) % 10);
            digits[1] = DIGIT_W'((m / 10) % 10);
            digits[2] = DIGIT_W'(m % 10);
            digits[3] = DIGIT_W'(s / 10);
            digits[4] = DIGIT_W'(s % 10);
         end else begin
            digits[0] = DIGIT_W'((m / 10) % 10);
            digits[1] = DIGIT_W'(m % 10);
            digits[2] = DIGIT_W'(s / 10);
            digits[3] = DIGIT_W'(s % 10);
            digits[4] = '0;
         end
         dv  = digits[rq.digit_position];
         row = 32'(rq.row_index);
         r.glyph.digit_value = dv;

         // pick the shape of this glyph row
         if (row >= DEF_GLYPH_HEIGHT)
            shape = ROW_BLANK;
         else if (dv == 1)
            shape = ROW_ONE;
         else if (row == 0)
            shape = (dv == 4) ? ROW_BOX : ROW_FULL;
         else if (row == GLYPH_LAST)
            shape = (dv == 4 || dv == 7) ? ROW_RIGHT : ROW_FULL;
         else if (row == GLYPH_MID)
            shape = (dv == 0) ? ROW_BOX : (dv == 7) ? ROW_RIGHT : ROW_FULL;
         else if (row < GLYPH_MID)
            shape = (dv inside {0, 4, 8, 9}) ? ROW_BOX :
                    (dv inside {5, 6}) ? ROW_LEFT : ROW_RIGHT;
         else
            shape = (dv inside {0, 6, 8}) ? ROW_BOX :
                    (dv == 2) ? ROW_LEFT : ROW_RIGHT;

         case (shape)
            ROW_FULL: begin
               r.glyph.row_mask  = MASK_FULL;
               r.glyph.row_width = RWIDTH_W'(DEF_GLYPH_WIDTH);
            end
            ROW_BOX: begin
               r.glyph.row_mask  = MASK_LEFT | MASK_RIGHT;
               r.glyph.row_width = RWIDTH_W'(DEF_GLYPH_WIDTH);
            end
            ROW_LEFT: begin
               r.glyph.row_mask  = MASK_LEFT;
               r.glyph.row_width = RWIDTH_W'(DEF_GLYPH_WIDTH);
            end
            ROW_RIGHT: begin
               r.glyph.row_mask  = MASK_RIGHT;
               r.glyph.row_width = RWIDTH_W'(DEF_GLYPH_WIDTH);
            end
            ROW_ONE: begin
               r.glyph.row_mask  = MASK_LEFT;
               r.glyph.row_width = RWIDTH_W'(1);
            end
            default: begin
               r.glyph.row_mask  = '0;
               r.glyph.row_width = '0;
            end
         endcase
      end
      return r;
   endfunction

   task automatic add_request(input logic [ACTION_W-1:0] action, input int unsigned secs,
                              input int unsigned row, input int unsigned pos);
      request_type rq;
      rq.action         = action;
      rq.load_seconds   = LOAD_W'(secs);
      rq.row_index      = ROW_W'(row);
      rq.digit_position = POS_W'(pos);
      pending_requests.push_back(rq);
   endtask

   // mostly real glyph rows, now and then any row index, which may lie past the bottom
   function automatic int unsigned random_row();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, GLYPH_LAST);
   endfunction

   // mostly positions 0 to 4, now and then any position up to 7, which may lie beyond the display
   function automatic int unsigned random_position();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
   endfunction

   task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // driver: new request at the falling edge, held while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // stalled: payload and valid stay put
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
         req_valid          <= 1'b1;
         req_action         <= pending_requests[0].action;
         req_load_seconds   <= pending_requests[0].load_seconds;
         req_row_index      <= pending_requests[0].row_index;
         req_digit_position <= pending_requests[0].digit_position;
         void'(pending_requests.pop_front());
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            // end of a burst: new length, and a gap unless back-to-back
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall pattern changes every phase, plus one long hold to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && responses_checked >= HOLD_AFTER_RESPONSES) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            phase_left = $urandom_range(16, 96);
         end
         phase_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // monitor: predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            next_display = timer_display_predict({req_action, req_load_seconds,
                                                  req_row_index, req_digit_position});
            expected_displays.push_back(next_display);
            requests_accepted++;
            if (next_display.status.load_rejected) rejected_loads++;
            if (next_display.status.beep) expired_countdowns++;
            if (next_display.glyph.row_width != 0) begin
               lit_rows++;
               if (next_display.status.digit_count == COUNT_LONG) long_display_rows++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            responses_checked++;
            if (expected_displays.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatch_count++;
            end else begin
               oldest_display = expected_displays.pop_front();
               check_field("minutes_left",  16'(oldest_display.status.minutes_left),
                           16'(rsp_minutes_left));
               check_field("seconds_left",  16'(oldest_display.status.seconds_left),
                           16'(rsp_seconds_left));
               check_field("running",       16'(oldest_display.status.running),
                           16'(rsp_running));
               check_field("beep",          16'(oldest_display.status.beep),
                           16'(rsp_beep));
               check_field("load_rejected", 16'(oldest_display.status.load_rejected),
                           16'(rsp_load_rejected));
               check_field("digit_count",   16'(oldest_display.status.digit_count),
                           16'(rsp_digit_count));
               check_field("digit_value",   16'(oldest_display.glyph.digit_value),
                           16'(rsp_digit_value));
               check_field("row_mask",      16'(oldest_display.glyph.row_mask),
                           16'(rsp_row_mask));
               check_field("row_width",     16'(oldest_display.glyph.row_width),
                           16'(rsp_row_width));
            end
         end
      end
   end

   // watchdog: too long without any handshake means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("countdown_timer_mm_ss_display_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int unsigned secs, run, pick;
      int          random_start;

      // directed: reset state, stopped ticks, load limits, borrow, digit shapes
      add_request(ACT_QUERY, 0, 0, 0);         // fresh timer shows zeros
      add_request(ACT_TICK, 0, 0, 0);          // tick while stopped
      add_request(ACT_LOAD, 16383, 15, 7);     // all-ones load rejected
      add_request(ACT_LOAD, 10000, 0, 0);      // first rejected value
      add_request(ACT_LOAD, 0, 0, 0);          // zero load still starts
      add_request(ACT_TICK, 0, 0, 0);          // beeps at once
      add_request(ACT_TICK, 0, 0, 0);          // stopped again
      add_request(ACT_LOAD, 9999, 0, 0);       // largest load, five digits
      add_request(ACT_QUERY, 0, 0, 0);         // hundreds digit one
      add_request(ACT_QUERY, 0, GLYPH_LAST, 4);  // bottom row of nine
      add_request(ACT_QUERY, 0, GLYPH_MID, 2);   // middle bar of six
      add_request(ACT_QUERY, 0, 15, 3);        // row past the glyph
      add_request(ACT_QUERY, 0, 3, 7);         // position past the display
      add_request(ACT_IDLE, 16383, 15, 7);     // unused action
      add_request(ACT_LOAD, 6000, 0, 0);       // exactly 100 minutes
      add_request(ACT_TICK, 0, 0, 0);          // borrow drops to four digits
      add_request(ACT_QUERY, 0, 2, 4);         // fifth digit no longer shown
      add_request(ACT_QUERY, 0, DEF_GLYPH_HEIGHT, 0);  // first blank row
      add_request(ACT_LOAD, 60, 0, 0);         // one minute
      add_request(ACT_TICK, 0, 0, 0);          // borrow to 0:59
      add_request(ACT_QUERY, 0, 8, 3);         // lower side of nine
      add_request(ACT_LOAD, 4, 0, 0);
      add_request(ACT_QUERY, 0, 0, 3);         // top of four is a box
      add_request(ACT_QUERY, 0, GLYPH_LAST, 3);  // bottom of four
      add_request(ACT_QUERY, 0, 7, 2);         // lower side of zero

      // random: countdown sessions with ticks and queries, the rest noise
      random_start = pending_requests.size();
      while (pending_requests.size() - random_start < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 4))
               0, 1:    secs = $urandom_range(0, 40);      // short enough to run out
               2:       secs = $urandom_range(41, 130);
               3:       secs = $urandom_range(5990, 6010); // around 100 minutes
               default: secs = $urandom_range(0, DEF_MAX_LOAD_SECONDS);
            endcase
            add_request(ACT_LOAD, secs, random_row(), random_position());
            run = $urandom_range(4, 45);
            repeat (run) begin
               pick = $urandom_range(0, 19);
               if (pick < 12)
                  add_request(ACT_TICK, $urandom_range(0, 16383), $urandom_range(0, 15),
                              $urandom_range(0, 7));
               else if (pick < 19)
                  add_request(ACT_QUERY, $urandom_range(0, 16383), random_row(),
                              random_position());
               else
                  add_request(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 16383),
                              $urandom_range(0, 15), $urandom_range(0, 7));
            end
         end else begin
            add_request(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 16383),
                        $urandom_range(0, 15), $urandom_range(0, 7));
         end
      end

      // reset held from the start, released at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the last request to go in and every response to come out
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_displays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d rejected loads, %0d countdowns run out",
               requests_accepted, rejected_loads, expired_countdowns);
      $display("%0d lit glyph rows checked, %0d of them on the five-digit display",
               lit_rows, long_display_rows);
      if (mismatch_count == 0 && expected_displays.size() == 0)
         $display("countdown_timer_mm_ss_display_unit verification clean");
      else
         $display("countdown_timer_mm_ss_display_unit verification failed");
      $finish;
   end

endmodule
